@@ hw/rtl/ptws_pkg.sv @@
// ----------------------------------------------------------------------------
// ptws_pkg: shared types and constants of the prefix tree word store
// Stream word widths, command codes and the packed sideband layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package ptws_pkg;

	// field widths
	localparam int CMD_W    = 2;
	localparam int LETTER_W = 5;

	// stream word widths
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 8;

	// command codes; any other code acts as a prefix check
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;

	// input sideband, lowest bit first: command, no_letter
	typedef struct packed {
		logic             no_letter;
		logic [CMD_W-1:0] command;
	} in_user_t;

	// result word, lowest bit first: found, pool_full
	typedef struct packed {
		logic pool_full;
		logic found;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptws_ram.sv @@
// ----------------------------------------------------------------------------
// ptws_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/prefix_tree_word_store_top.sv @@
// A letter word is accepted in the idle state; the child table read returns in
// the walk state, which updates the cursor. The last word of a run then passes
// the finish state (insert, prefix, missed search) or the finish and end mark
// states (search) before the result is registered on the master side. Reset:
// arst_n clears control state, then a clearing pass over the MAX_NODES*ALPHABET
// child slots zeroes both tables with s_tready low. Words are taken only in idle.
// ----------------------------------------------------------------------------
// prefix_tree_word_store_top: word store held as a prefix tree
// Walks a node pool one letter per word, allocating children on insert and
// reporting found / pool_full after the last word of each run.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_tree_word_store_top
	import ptws_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET  = 26
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [4:0] letter, rest zero
	input  wire logic [S_TUSER_W-1:0] s_tuser,  // [1:0] command, [2] no_letter
	input  wire logic                 s_tlast,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata   // [0] found, [1] pool_full, rest zero
);

	localparam int DEPTH    = MAX_NODES * ALPHABET;
	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int CHILD_AW = $clog2(DEPTH);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_MARK = 3'd4;

	logic [2:0]          state_q;
	logic [CHILD_AW-1:0] clr_q;
	logic [NODE_W-1:0]   walk_q;
	logic [NODE_W:0]     next_free_q;
	logic                miss_q;
	logic                fail_q;
	logic [CMD_W-1:0]    cmd_q;
	logic                last_q;
	logic [CHILD_AW-1:0] slot_q;
	logic                m_valid_q;
	result_t             res_q;

	in_user_t            in_user;
	logic [LETTER_W-1:0] in_letter;
	logic                accept;
	logic                letter_ok;
	logic                walk_req;
	logic [CHILD_AW-1:0] slot;
	logic                clr_done;
	logic                clr_end_we;

	logic                child_we;
	logic [CHILD_AW-1:0] child_waddr;
	logic [NODE_W-1:0]   child_wdata;
	logic [NODE_W-1:0]   child_rdata;
	logic                child_absent;
	logic                pool_empty;
	logic                alloc;

	logic                end_we;
	logic [NODE_W-1:0]   end_waddr;
	logic                end_wdata;
	logic                end_rdata;
	logic                word_ok;
	logic                result_set;
	result_t             result;

	// unpack the input word
	assign in_user   = in_user_t'(s_tuser);
	assign in_letter = s_tdata[LETTER_W-1:0];

	// take a word only when idle and the result register is free
	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign letter_ok = (32'(in_letter) < ALPHABET);
	assign walk_req  = !in_user.no_letter && !miss_q && !fail_q && letter_ok;
	assign slot      = CHILD_AW'(walk_q) * CHILD_AW'(ALPHABET) + CHILD_AW'(in_letter);

	// clearing pass bookkeeping
	assign clr_done   = (clr_q == CHILD_AW'(DEPTH - 1));
	assign clr_end_we = (clr_q < CHILD_AW'(MAX_NODES));

	// child allocation on a missing entry
	assign child_absent = (child_rdata == '0);
	assign pool_empty   = (next_free_q == (NODE_W + 1)'(MAX_NODES));
	assign alloc        = (state_q == ST_WALK) && child_absent &&
	                      (cmd_q == CMD_INSERT) && !pool_empty;

	assign child_we    = (state_q == ST_CLR) || alloc;
	assign child_waddr = (state_q == ST_CLR) ? clr_q : slot_q;
	assign child_wdata = (state_q == ST_CLR) ? '0 : next_free_q[NODE_W-1:0];

	ptws_ram #(
		.WIDTH (NODE_W),
		.DEPTH (DEPTH)
	) u_child (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (slot),
		.rdata (child_rdata)
	);

	// end marks: cleared in the pass, set by a completed insert
	assign word_ok   = !miss_q && !fail_q;
	assign end_we    = ((state_q == ST_CLR) && clr_end_we) ||
	                   ((state_q == ST_FIN) && (cmd_q == CMD_INSERT) && word_ok);
	assign end_waddr = (state_q == ST_CLR) ? clr_q[NODE_W-1:0] : walk_q;
	assign end_wdata = (state_q != ST_CLR);

	ptws_ram #(
		.WIDTH (1),
		.DEPTH (MAX_NODES)
	) u_end (
		.clk   (clk),
		.we    (end_we),
		.waddr (end_waddr),
		.wdata (end_wdata),
		.raddr (walk_q),
		.rdata (end_rdata)
	);

	// result of the finishing states
	always_comb begin
		result_set       = 1'b0;
		result.found     = 1'b0;
		result.pool_full = 1'b0;
		if (state_q == ST_MARK) begin
			result_set   = 1'b1;
			result.found = end_rdata;
		end else if (state_q == ST_FIN) begin
			case (cmd_q)
				CMD_INSERT: begin
					result_set       = 1'b1;
					result.found     = word_ok;
					result.pool_full = fail_q;
				end
				CMD_SEARCH: begin
					result_set = !word_ok;
				end
				default: begin
					result_set   = 1'b1;
					result.found = word_ok;
				end
			endcase
		end
	end

	// sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			walk_q      <= '0;
			next_free_q <= (NODE_W + 1)'(1);
			miss_q      <= 1'b0;
			fail_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (!in_user.no_letter && !letter_ok) begin
							miss_q <= 1'b1;
						end
						if (walk_req) begin
							state_q <= ST_WALK;
						end else if (s_tlast) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WALK: begin
					if (!child_absent) begin
						walk_q <= child_rdata;
					end else if (cmd_q != CMD_INSERT) begin
						miss_q <= 1'b1;
					end else if (pool_empty) begin
						fail_q <= 1'b1;
					end else begin
						walk_q      <= next_free_q[NODE_W-1:0];
						next_free_q <= next_free_q + 1'b1;
					end
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if ((cmd_q == CMD_SEARCH) && word_ok) begin
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_IDLE;
						walk_q  <= '0;
						miss_q  <= 1'b0;
						fail_q  <= 1'b0;
					end
				end
				ST_MARK: begin
					state_q <= ST_IDLE;
					walk_q  <= '0;
					miss_q  <= 1'b0;
					fail_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the accepted word's command, last flag and table slot
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_user.command;
			last_q <= s_tlast;
			slot_q <= slot;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (result_set) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (result_set) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'(res_q);

endmodule

`default_nettype wire

@@ hw/rtl/ptws_checker.sv @@
// ----------------------------------------------------------------------------
// ptws_checker: port-level checks of the prefix tree word store
// Watches both stream sides of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ptws_checker
	import ptws_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [S_TDATA_W-1:0] s_tdata,
	input wire logic [S_TUSER_W-1:0] s_tuser,
	input wire logic                 s_tlast,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// found and pool_full never together, padding stays zero
	a_out_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[M_TDATA_W-1:2] == '0))
		else $error("result word has conflicting flags");

	// no new input word while a result is stuck
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while result stalled");

	// a word that is not last raises no result right after it
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
		else $error("result raised by a word that is not last");

	// no result appears in the cycle right after acceptance
	a_min_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast && (s_tdata[7:5] == '0) && !s_tuser[2]
		|=> !$rose(m_tvalid))
		else $error("result raised too early");

endmodule

bind prefix_tree_word_store_top ptws_checker u_ptws_checker (.*);

`default_nettype wire

@@ tb/ptws_lookup_checker.sv @@
// ----------------------------------------------------------------------------
// ptws_lookup_checker: result checker for the prefix tree word store
// Watches both stream channels. Keeps its own copy of the node pool, the
// child links and the end-of-word marks. Works out the result owed for every
// word that closes a run, and compares each result word with the oldest one.
// ----------------------------------------------------------------------------
module ptws_lookup_checker
	import ptws_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET  = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] letter, rest zero
	input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] command, [2] no_letter
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // [0] found, [1] pool_full, rest zero
	output int                   failures,
	output int                   owed_count,
	output int                   results_seen,
	output int                   found_seen,
	output int                   full_seen
);

	localparam int SLOTS = MAX_NODES * ALPHABET;

	// shadow of the tree
	int       kid [0:SLOTS-1];
	bit       marked [0:MAX_NODES-1];
	int       fresh_node;
	int       cursor;
	bit       off_tree;
	bit       out_of_pool;

	// results owed, oldest first
	result_t  owed_results [$];
	result_t  want;
	in_user_t seen_user;
	int       errs;
	int       n_res;
	int       n_found;
	int       n_full;

	// step the cursor one letter down, allocating on insert
	task automatic take_letter(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] ltr);
		int slot;
		int child;
		if (off_tree || out_of_pool)
			return;
		if (int'(ltr) >= ALPHABET) begin
			off_tree = 1'b1;
			return;
		end
		slot  = cursor * ALPHABET + int'(ltr);
		child = kid[slot];
		if (child == 0) begin
			if (cmd != CMD_INSERT) begin
				off_tree = 1'b1;
				return;
			end
			if (fresh_node >= MAX_NODES) begin
				out_of_pool = 1'b1;
				return;
			end
			child = fresh_node;
			fresh_node++;
			kid[slot] = child;
		end
		cursor = child;
	endtask

	// close the word: owe one result, return to the root
	task automatic close_word(input logic [CMD_W-1:0] cmd);
		result_t r;
		r = '0;
		if (cmd == CMD_INSERT) begin
			if (out_of_pool) begin
				r.pool_full = 1'b1;
			end else if (!off_tree) begin
				marked[cursor] = 1'b1;
				r.found = 1'b1;
			end
		end else if (cmd == CMD_SEARCH) begin
			r.found = !off_tree && !out_of_pool && marked[cursor];
		end else begin
			r.found = !off_tree && !out_of_pool;
		end
		owed_results.push_back(r);
		cursor      = 0;
		off_tree    = 1'b0;
		out_of_pool = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// empty tree, root only
			for (int i = 0; i < SLOTS; i++)
				kid[i] = 0;
			for (int i = 0; i < MAX_NODES; i++)
				marked[i] = 1'b0;
			fresh_node  = 1;
			cursor      = 0;
			off_tree    = 1'b0;
			out_of_pool = 1'b0;
			owed_results.delete();
			errs    = 0;
			n_res   = 0;
			n_found = 0;
			n_full  = 0;
			failures     <= 0;
			owed_count   <= 0;
			results_seen <= 0;
			found_seen   <= 0;
			full_seen    <= 0;
		end else begin
			// compare a result word against the oldest owed result
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					errs++;
					$display("%0t: unexpected result word %h, nothing owed", $time, m_tdata);
				end else begin
					want = owed_results.pop_front();
					n_res++;
					if (want.found)
						n_found++;
					if (want.pool_full)
						n_full++;
					if (m_tdata[0] !== want.found) begin
						errs++;
						$display("%0t: found expected %b actual %b",
							$time, want.found, m_tdata[0]);
					end
					if (m_tdata[1] !== want.pool_full) begin
						errs++;
						$display("%0t: pool_full expected %b actual %b",
							$time, want.pool_full, m_tdata[1]);
					end
					if (m_tdata[M_TDATA_W-1:2] !== '0) begin
						errs++;
						$display("%0t: padding expected 0 actual %h",
							$time, m_tdata[M_TDATA_W-1:2]);
					end
				end
			end
			// predict from an accepted letter word
			if (s_tvalid && s_tready) begin
				seen_user = in_user_t'(s_tuser);
				if (!seen_user.no_letter)
					take_letter(seen_user.command, s_tdata[LETTER_W-1:0]);
				if (s_tlast)
					close_word(seen_user.command);
			end
			failures     <= errs;
			owed_count   <= owed_results.size();
			results_seen <= n_res;
			found_seen   <= n_found;
			full_seen    <= n_full;
		end
	end

endmodule

@@ tb/prefix_tree_word_store_top_test.sv @@
// ----------------------------------------------------------------------------
// prefix_tree_word_store_top_test: stream test of the prefix tree word store
// Sends directed words for the empty word, bad letters, missing paths and
// mixed commands, then random inserts, lookups and noise until the node pool
// runs out and beyond, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module prefix_tree_word_store_top_test;
	import ptws_pkg::*;

	localparam int MAX_NODES = 1024;
	localparam int ALPHABET  = 26;

	// command codes without a package name
	localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

	localparam int FILL_END  = 1150;  // words mostly grow the tree until here
	localparam int ITEMS_END = 1250;  // total letter words sent
	localparam int CALM_TAIL = 150;   // no idling over the last words
	localparam int LEX_MAX   = 256;
	localparam int WORD_MAX  = 24;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [4:0] letter, rest zero
	logic [S_TUSER_W-1:0] s_tuser;   // [1:0] command, [2] no_letter
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [0] found, [1] pool_full, rest zero

	int failures;
	int owed_count;
	int results_seen;
	int found_seen;
	int full_seen;

	int sent;
	int gap_pct;
	int stall_pct;

	// words stored so far, reused for lookups
	logic [LETTER_W-1:0] lex [0:LEX_MAX-1][0:WORD_MAX-1];
	int                  lex_len [0:LEX_MAX-1];
	int                  lex_n;
	logic [LETTER_W-1:0] wbuf [0:WORD_MAX];

	prefix_tree_word_store_top #(
		.MAX_NODES(MAX_NODES),
		.ALPHABET (ALPHABET)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	ptws_lookup_checker #(
		.MAX_NODES(MAX_NODES),
		.ALPHABET (ALPHABET)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.failures    (failures),
		.owed_count  (owed_count),
		.results_seen(results_seen),
		.found_seen  (found_seen),
		.full_seen   (full_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// give up well past the slowest correct run
	initial begin
		#5000000;
		$display("prefix_tree_word_store_top verification failed");
		$finish;
	end

	// result side: random stall bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// send one letter word, holding it until accepted
	task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] ltr,
			input logic nol, input logic lst);
		in_user_t u;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		u.command   = cmd;
		u.no_letter = nol;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-LETTER_W){1'b0}}, ltr};
		s_tuser  <= u;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// send wbuf[0:n-1] as one run; an empty run is a single no-letter word
	task automatic send_word(input logic [CMD_W-1:0] cmd, input int n);
		if (n == 0) begin
			push_item(cmd, LETTER_W'($urandom_range(0, 31)), 1'b1, 1'b1);
		end else begin
			for (int i = 0; i < n; i++)
				push_item(cmd, wbuf[i], 1'b0, i == n - 1);
		end
	endtask

	task automatic word3(input logic [CMD_W-1:0] cmd, input int n,
			input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b,
			input logic [LETTER_W-1:0] c);
		wbuf[0] = a;
		wbuf[1] = b;
		wbuf[2] = c;
		send_word(cmd, n);
	endtask

	// copy a stored word into wbuf, return its length
	function automatic int pick_stored(input int idx);
		for (int i = 0; i < lex_len[idx]; i++)
			wbuf[i] = lex[idx][i];
		return lex_len[idx];
	endfunction

	// keep a word for later lookups
	task automatic remember(input int n);
		int slot;
		slot = (lex_n < LEX_MAX) ? lex_n : $urandom_range(0, LEX_MAX - 1);
		if (lex_n < LEX_MAX)
			lex_n++;
		for (int i = 0; i < n; i++)
			lex[slot][i] = wbuf[i];
		lex_len[slot] = n;
	endtask

	// one random chunk of stimulus
	task automatic random_chunk();
		int pick;
		int n;
		int idx;
		int fresh_pct;
		logic [CMD_W-1:0] cmd;
		fresh_pct = (sent < FILL_END) ? 96 : 35;
		pick = $urandom_range(1, 100);
		if (pick <= fresh_pct || lex_n == 0) begin
			// fresh insert, mostly long so the pool fills
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(3, WORD_MAX);
			for (int i = 0; i < n; i++)
				wbuf[i] = LETTER_W'($urandom_range(0, ALPHABET - 1));
			send_word(CMD_INSERT, n);
			remember(n);
		end else if (pick <= fresh_pct + (100 - fresh_pct) * 6 / 10) begin
			// lookups built on a stored word
			idx = $urandom_range(0, lex_n - 1);
			n = pick_stored(idx);
			case ($urandom_range(0, 5))
				0: begin
					send_word(CMD_SEARCH, n);
				end
				1: begin
					send_word(CMD_SEARCH, $urandom_range(1, n));
				end
				2: begin
					cmd = $urandom_range(0, 1) ? CMD_PREFIX : CMD_SPARE;
					send_word(cmd, $urandom_range(1, n));
				end
				3: begin
					send_word(CMD_INSERT, $urandom_range(1, n));
				end
				4: begin
					wbuf[$urandom_range(0, n - 1)] = LETTER_W'($urandom_range(0, ALPHABET - 1));
					send_word(CMD_SEARCH, n);
				end
				default: begin
					wbuf[n] = LETTER_W'($urandom_range(0, ALPHABET - 1));
					send_word($urandom_range(0, 1) ? CMD_SEARCH : CMD_PREFIX, n + 1);
				end
			endcase
		end else if (pick <= fresh_pct + (100 - fresh_pct) * 8 / 10) begin
			// stored word with a random command per letter
			idx = $urandom_range(0, lex_n - 1);
			n = pick_stored(idx);
			for (int i = 0; i < n; i++)
				push_item(CMD_W'($urandom_range(0, 3)), wbuf[i], 1'b0, i == n - 1);
		end else if (pick <= fresh_pct + (100 - fresh_pct) * 9 / 10) begin
			// empty word under any command
			send_word(CMD_W'($urandom_range(0, 3)), 0);
		end else begin
			// noise: any field value, bad letters, stray no-letter words
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				push_item(CMD_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)),
					$urandom_range(0, 7) == 0, i == n - 1);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		s_tlast   = 1'b0;
		sent      = 0;
		lex_n     = 0;
		gap_pct   = 20;
		stall_pct = 20;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty word on a bare root, then marked
		word3(CMD_SEARCH, 0, 0, 0, 0);
		word3(CMD_PREFIX, 0, 0, 0, 0);
		word3(CMD_INSERT, 0, 0, 0, 0);
		word3(CMD_SEARCH, 0, 0, 0, 0);
		// insert "az" with a stray no-letter word in the middle
		push_item(CMD_INSERT, 5'd0, 1'b0, 1'b0);
		push_item(CMD_INSERT, 5'd31, 1'b1, 1'b0);
		push_item(CMD_INSERT, 5'd25, 1'b0, 1'b1);
		word3(CMD_SEARCH, 2, 0, 25, 0);
		word3(CMD_SEARCH, 1, 0, 0, 0);
		word3(CMD_PREFIX, 1, 0, 0, 0);
		// letters past the alphabet
		word3(CMD_SEARCH, 1, 26, 0, 0);
		word3(CMD_INSERT, 1, 31, 0, 0);
		word3(CMD_PREFIX, 2, 0, 27, 0);
		// unused command acts as prefix check
		word3(CMD_SPARE, 2, 0, 25, 0);
		// missing paths
		word3(CMD_SEARCH, 1, 1, 0, 0);
		word3(CMD_PREFIX, 2, 1, 25, 0);
		// mixed commands: insert a letter, then search a missing one
		push_item(CMD_INSERT, 5'd16, 1'b0, 1'b0);
		push_item(CMD_SEARCH, 5'd17, 1'b0, 1'b1);
		// run closed by a no-letter word at an unmarked node
		push_item(CMD_SEARCH, 5'd0, 1'b0, 1'b0);
		push_item(CMD_SEARCH, 5'd3, 1'b1, 1'b1);

		// random part, idling mode redrawn every few dozen words
		while (sent < ITEMS_END) begin
			if (sent >= ITEMS_END - CALM_TAIL) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 10;
					default: gap_pct = 35;
				endcase
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			random_chunk();
		end
		s_tvalid <= 1'b0;

		// drain owed results, then let the block settle
		while (owed_count != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("sent %0d letter words, checked %0d results", sent, results_seen);
		$display("results with found set: %0d, with pool_full set: %0d", found_seen, full_seen);
		if (failures == 0 && owed_count == 0) begin
			$display("prefix_tree_word_store_top verification clean");
		end else begin
			$display("prefix_tree_word_store_top verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ptws_pkg.sv
hw/rtl/ptws_ram.sv
hw/rtl/prefix_tree_word_store_top.sv
hw/rtl/ptws_checker.sv
tb/ptws_lookup_checker.sv
tb/prefix_tree_word_store_top_test.sv
